/* hdl/four_channel_level_averager_top_macros.svh */
// assertion macros for the level averager
`ifndef FOUR_CHANNEL_LEVEL_AVERAGER_TOP_MACROS_SVH
`define FOUR_CHANNEL_LEVEL_AVERAGER_TOP_MACROS_SVH

// same-cycle implication under synchronous reset
`define FCLA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcla assertion failed");

// next-cycle implication under synchronous reset
`define FCLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcla assertion failed");

`endif

/* hdl/fcla_pkg.sv */
package fcla_pkg;

  localparam int NUM_CH     = 4;
  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 7;
  localparam int MEAN_W     = SAMPLE_W;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  localparam int WINDOW    = 500;
  localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W     = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int DIV_SH    = SUM_W;
  localparam int DIV_PROD_W = 2 * SUM_W + 1;
  localparam int DIV_RECIP = (1 << DIV_SH) / WINDOW;

  localparam int FULL_MEAN  = 650;
  localparam int EMPTY_MEAN = 20;
  localparam int SCALE_NUM  = 15873;
  localparam int SCALE_DEN  = 100000;
  localparam int FULL_LEVEL = 100;

  localparam int T_W        = $clog2(FULL_MEAN - EMPTY_MEAN + 1);
  localparam int Y_W        = $clog2(((1 << T_W) - 1) * SCALE_NUM + 1);
  localparam int MAP_SH     = Y_W;
  localparam int MAP_PROD_W = 2 * Y_W;
  localparam int MAP_RECIP  = (1 << MAP_SH) / SCALE_DEN;

  localparam int LANE_STAGES = 6;
  localparam int PIPE_STAGES = LANE_STAGES + 1;

  typedef enum logic [1:0] {
    CLS_EMPTY,
    CLS_MID,
    CLS_FULL
  } level_cls_t;

  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] ring_row_t;

  typedef struct packed {
    logic                   acc;
    logic [LANE_STAGES-1:0] load;
  } lane_ctrl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch3;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_ch0;
    logic [LEVEL_W-1:0] level_ch1;
    logic [LEVEL_W-1:0] level_ch2;
    logic [LEVEL_W-1:0] level_ch3;
  } out_item_t;

endpackage

/* hdl/four_channel_level_averager_top.sv */
// Four-channel boxcar level averager. Each item carries one 12-bit sample per
// channel; the block keeps the last 500 sample sets in a ring RAM and a running
// sum per channel, and returns for every item one set of four levels in
// percent (0..100) mapped from each channel's truncated mean. One item is
// accepted per clock while in_ready is high; each result passes through the
// divide-and-map pipeline in each channel lane. The ring RAM read of the
// outgoing set is registered and issued ahead of its use. After reset the ring
// counts as all zeros with no clearing pass: until the first 500 items have
// arrived the zeros take part in the mean and the levels read low. With the
// output stalled, up to 7 items are taken before in_ready drops.
`include "four_channel_level_averager_top_macros.svh"

module four_channel_level_averager_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fcla_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fcla_pkg::out_item_t out_data
);
  import fcla_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic                    in_acc;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic                    filled_r, filled_nxt;
  logic [SLOT_W-1:0]       rd_addr;
  ring_row_t               smp_new;
  ring_row_t               rd_data;
  ring_row_t               smp_old;
  logic [PIPE_STAGES-1:0]  vld_r, vld_nxt;
  logic [PIPE_STAGES-1:0]  go;
  lane_ctrl_t              lane_ctrl;
  logic [NUM_CH-1:0][LEVEL_W-1:0] lane_level;
  out_item_t               out_data_r;

  assign smp_new[0] = in_data.sample_ch0;
  assign smp_new[1] = in_data.sample_ch1;
  assign smp_new[2] = in_data.sample_ch2;
  assign smp_new[3] = in_data.sample_ch3;

  always_comb begin
    go[PIPE_STAGES-1] = !vld_r[PIPE_STAGES-1] || out_ready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      go[i] = !vld_r[i] || go[i+1];
    end
  end

  assign in_ready = go[0];
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    vld_nxt[0] = go[0] ? in_acc : vld_r[0];
    for (int i = 1; i < PIPE_STAGES; i++) begin
      vld_nxt[i] = go[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  assign slot_nxt   = (slot_r == SLOT_LAST) ? '0 : SLOT_W'(slot_r + 1'b1);
  assign filled_nxt = filled_r || (in_acc && (slot_r == SLOT_LAST));
  assign rd_addr    = in_acc ? slot_nxt : slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      slot_r   <= '0;
      filled_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      filled_r <= filled_nxt;
      if (in_acc) begin
        slot_r <= slot_nxt;
      end
    end
  end

  fcla_ring_ram u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (slot_r),
    .wdata (smp_new),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // slots not yet written in the first pass read as zero
  assign smp_old = filled_r ? rd_data : '0;

  assign lane_ctrl.acc  = in_acc;
  assign lane_ctrl.load = {go[LANE_STAGES-1:1], in_acc};

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    fcla_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (lane_ctrl),
      .sample_new (smp_new[ch]),
      .sample_old (smp_old[ch]),
      .level      (lane_level[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (go[PIPE_STAGES-1]) begin
      out_data_r.level_ch0 <= lane_level[0];
      out_data_r.level_ch1 <= lane_level[1];
      out_data_r.level_ch2 <= lane_level[2];
      out_data_r.level_ch3 <= lane_level[3];
    end
  end

  assign out_valid = vld_r[PIPE_STAGES-1];
  assign out_data  = out_data_r;

  `FCLA_ASSERT_NEXT(a_slot_wrap, clk, rst_n, in_acc && (slot_r == SLOT_LAST), (slot_r == '0) && filled_r)
  `FCLA_ASSERT_NEXT(a_filled_holds, clk, rst_n, filled_r, filled_r)
  `FCLA_ASSERT_NOW(a_full_blocks, clk, rst_n, (&vld_r) && !out_ready, !in_ready)
  `FCLA_ASSERT_NEXT(a_acc_enters, clk, rst_n, in_acc, vld_r[0])

endmodule

/* hdl/fcla_ring_ram.sv */
module fcla_ring_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [fcla_pkg::SLOT_W-1:0] waddr,
  input  fcla_pkg::ring_row_t       wdata,
  input  logic [fcla_pkg::SLOT_W-1:0] raddr,
  output fcla_pkg::ring_row_t       rdata
);
  import fcla_pkg::*;

  ring_row_t ring_mem [WINDOW];
  ring_row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[waddr] <= wdata;
    end
  end

  // write-first read so a same-slot write is seen at once
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= ring_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/fcla_lane.sv */
module fcla_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fcla_pkg::lane_ctrl_t          ctrl,
  input  logic [fcla_pkg::SAMPLE_W-1:0] sample_new,
  input  logic [fcla_pkg::SAMPLE_W-1:0] sample_old,
  output logic [fcla_pkg::LEVEL_W-1:0]  level
);
  import fcla_pkg::*;

  localparam logic [SUM_W:0]      DIV_RECIP_V = (SUM_W+1)'(DIV_RECIP);
  localparam logic [SUM_W-1:0]    WIN_V       = SUM_W'(WINDOW);
  localparam logic [Y_W-1:0]      MAP_RECIP_V = Y_W'(MAP_RECIP);
  localparam logic [Y_W-1:0]      DEN_V       = Y_W'(SCALE_DEN);

  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [SUM_W-1:0]      s1_sum_r;
  logic [DIV_PROD_W-1:0] s2_prod_r;
  logic [SUM_W-1:0]      s2_sum_r;
  logic [MEAN_W-1:0]     s3_q_r;
  logic [SUM_W-1:0]      s3_rem_r;
  logic [Y_W-1:0]        s4_y_r;
  level_cls_t            s4_cls_r;
  logic [MAP_PROD_W-1:0] s5_prod_r;
  logic [Y_W-1:0]        s5_y_r;
  level_cls_t            s5_cls_r;
  logic [LEVEL_W-1:0]    s6_q_r;
  logic [Y_W-1:0]        s6_rem_r;
  level_cls_t            s6_cls_r;

  logic [MEAN_W-1:0]     q0_c;
  logic [MEAN_W-1:0]     mean_c;
  logic [T_W-1:0]        t_c;
  level_cls_t            cls_c;
  logic [LEVEL_W-1:0]    q2_c;
  logic [LEVEL_W-1:0]    lvl_mid_c;

  assign sum_nxt = sum_r - SUM_W'(sample_old) + SUM_W'(sample_new);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.acc) begin
      sum_r <= sum_nxt;
    end
  end

  // mean by reciprocal, then one correction step
  assign q0_c   = s2_prod_r[DIV_SH +: MEAN_W];
  assign mean_c = (s3_rem_r >= WIN_V) ? MEAN_W'(s3_q_r + 1'b1) : s3_q_r;
  assign t_c    = T_W'(mean_c - MEAN_W'(EMPTY_MEAN));

  always_comb begin
    if (mean_c >= MEAN_W'(FULL_MEAN)) begin
      cls_c = CLS_FULL;
    end else if (mean_c < MEAN_W'(EMPTY_MEAN)) begin
      cls_c = CLS_EMPTY;
    end else begin
      cls_c = CLS_MID;
    end
  end

  assign q2_c      = s5_prod_r[MAP_SH +: LEVEL_W];
  assign lvl_mid_c = (s6_rem_r >= DEN_V) ? LEVEL_W'(s6_q_r + 1'b1) : s6_q_r;

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_sum_r <= sum_nxt;
    end
    if (ctrl.load[1]) begin
      s2_prod_r <= DIV_PROD_W'(s1_sum_r) * DIV_PROD_W'(DIV_RECIP_V);
      s2_sum_r  <= s1_sum_r;
    end
    if (ctrl.load[2]) begin
      s3_q_r   <= q0_c;
      s3_rem_r <= s2_sum_r - SUM_W'(SUM_W'(q0_c) * WIN_V);
    end
    if (ctrl.load[3]) begin
      s4_y_r   <= Y_W'(t_c) * Y_W'(SCALE_NUM);
      s4_cls_r <= cls_c;
    end
    if (ctrl.load[4]) begin
      s5_prod_r <= MAP_PROD_W'(s4_y_r) * MAP_PROD_W'(MAP_RECIP_V);
      s5_y_r    <= s4_y_r;
      s5_cls_r  <= s4_cls_r;
    end
    if (ctrl.load[5]) begin
      s6_q_r   <= q2_c;
      s6_rem_r <= s5_y_r - Y_W'(Y_W'(q2_c) * DEN_V);
      s6_cls_r <= s5_cls_r;
    end
  end

  always_comb begin
    unique case (s6_cls_r)
      CLS_FULL:  level = LEVEL_W'(FULL_LEVEL);
      CLS_MID:   level = lvl_mid_c;
      default:   level = '0;
    endcase
  end

endmodule

/* sim/tb_four_channel_level_averager_top.sv */
module tb_four_channel_level_averager_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcla_pkg::*;

  localparam int SET_COUNT = 850;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  four_channel_level_averager_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  in_item_t    sample_sets[$];
  out_item_t   level_queue[$];

  // predictor state: ring of past sample sets, running sums, next slot
  int unsigned window_sets[WINDOW][NUM_CH];
  int unsigned chan_sums[NUM_CH];
  int unsigned write_pos = 0;

  logic in_took = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   ready_mode = 0;
  int   ready_left = 0;
  int   error_count = 0;
  int   sets_taken = 0;
  int   levels_checked = 0;
  int   cnt_empty = 0;
  int   cnt_mid = 0;
  int   cnt_full = 0;

  function automatic logic [LEVEL_W-1:0] level_from_mean(int unsigned m);
    if (m >= FULL_MEAN) return LEVEL_W'(FULL_LEVEL);
    if (m < EMPTY_MEAN) return '0;
    return LEVEL_W'(((m - EMPTY_MEAN) * SCALE_NUM) / SCALE_DEN);
  endfunction

  function automatic out_item_t predict_levels(in_item_t s);
    int unsigned        fresh[NUM_CH];
    logic [LEVEL_W-1:0] lvl[NUM_CH];
    fresh = '{s.sample_ch0, s.sample_ch1, s.sample_ch2, s.sample_ch3};
    for (int c = 0; c < NUM_CH; c++) begin
      chan_sums[c] = chan_sums[c] - window_sets[write_pos][c] + fresh[c];
      window_sets[write_pos][c] = fresh[c];
      lvl[c] = level_from_mean(chan_sums[c] / WINDOW);
      if (lvl[c] == 0) cnt_empty++;
      else if (lvl[c] == FULL_LEVEL) cnt_full++;
      else cnt_mid++;
    end
    write_pos = (write_pos == WINDOW - 1) ? 0 : write_pos + 1;
    return '{level_ch0: lvl[0], level_ch1: lvl[1], level_ch2: lvl[2], level_ch3: lvl[3]};
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(int band);
    case (band)
      0: return SAMPLE_W'($urandom_range(0, 40));
      1: return SAMPLE_W'($urandom_range(0, 1300));
      2: return SAMPLE_W'($urandom_range(400, 900));
      3: return SAMPLE_W'($urandom_range(0, 300));
      default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    endcase
  endfunction

  task automatic add_set(int a, int b, int c, int d);
    sample_sets.push_back('{sample_ch0: SAMPLE_W'(a), sample_ch1: SAMPLE_W'(b),
                           sample_ch2: SAMPLE_W'(c), sample_ch3: SAMPLE_W'(d)});
  endtask

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  // sender: bursts of items with random gaps
  always @(negedge clk) begin : drive_samples
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0 || sample_sets.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_data  <= sample_sets.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // receiver: stall pattern switches mode every stretch
  always @(negedge clk) begin : drive_ready
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 120);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin : watch_ports
    out_item_t          want;
    logic [LEVEL_W-1:0] want_l[NUM_CH];
    logic [LEVEL_W-1:0] got_l[NUM_CH];
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        level_queue.push_back(predict_levels(in_data));
        sets_taken++;
      end
      if (out_valid && out_ready) begin
        if (level_queue.size() == 0) begin
          flag_error($sformatf("unexpected result %p", out_data));
        end else begin
          want = level_queue.pop_front();
          levels_checked++;
          want_l = '{want.level_ch0, want.level_ch1, want.level_ch2, want.level_ch3};
          got_l = '{out_data.level_ch0, out_data.level_ch1, out_data.level_ch2,
                    out_data.level_ch3};
          for (int c = 0; c < NUM_CH; c++) begin
            if (got_l[c] !== want_l[c])
              flag_error($sformatf("result %0d level_ch%0d: expected %0d, got %0d",
                                   levels_checked, c, want_l[c], got_l[c]));
          end
        end
      end
    end
  end

  initial begin : run_test
    int band[NUM_CH];
    int seg_len;
    logic [SAMPLE_W-1:0] v[NUM_CH];

    // directed: extremes, bit patterns, threshold values
    add_set(0, 0, 0, 0);
    add_set(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    add_set('hAAA, 'h555, 'hAAA, 'h555);
    add_set('h555, 'hAAA, 'h555, 'hAAA);
    add_set(0, SAMPLE_MAX, 0, SAMPLE_MAX);
    add_set(19, 20, 649, 650);
    for (int b = 0; b < SAMPLE_W; b++) add_set(1 << b, 1 << b, 1 << b, 1 << b);
    repeat (6) add_set(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);

    // random segments, each channel in its own band so the means sweep around
    while (sample_sets.size() < SET_COUNT) begin
      seg_len = $urandom_range(40, 160);
      if (seg_len > SET_COUNT - sample_sets.size())
        seg_len = SET_COUNT - sample_sets.size();
      foreach (band[c]) band[c] = $urandom_range(0, 4);
      repeat (seg_len) begin
        foreach (v[c]) v[c] = draw_sample(band[c]);
        add_set(v[0], v[1], v[2], v[3]);
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (sample_sets.size() != 0 || in_valid) @(posedge clk);
    while (level_queue.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("%0d sample sets sent, %0d level sets checked, ring wrapped %0d times",
             sets_taken, levels_checked, sets_taken / WINDOW);
    $display("channel levels seen: %0d at zero, %0d in between, %0d at full",
             cnt_empty, cnt_mid, cnt_full);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout: %0d items still queued, %0d results outstanding",
             sample_sets.size(), level_queue.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* four_channel_level_averager_top.f */
+incdir+hdl
hdl/fcla_pkg.sv
hdl/fcla_ring_ram.sv
hdl/fcla_lane.sv
hdl/four_channel_level_averager_top.sv
sim/tb_four_channel_level_averager_top.sv
